>>> rtl/crtd_pkg.sv
// Shared types, codes and constants of the concatenation residue trial divider.
package crtd_pkg;

	localparam int PW = 40;          // prime and residue width
	localparam int NW = 17;          // index width
	localparam int SW = 20;          // width of the decimal scale 10^digits(n)
	localparam int MW = 64;          // Barrett multiplier width
	localparam int StepW = 6;        // micro-step counter width
	localparam int DivSteps = 64;    // one quotient bit per cycle
	localparam int CalcSteps = 12;   // multiply, reduce and correct one entry

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_STEP  = 2'd2;

	localparam logic KIND_HIT    = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	typedef struct packed {
		logic [1:0]    func;
		logic [PW-1:0] prime;
		logic [PW-1:0] start_residue;
		logic [NW-1:0] number;
	} cmd_t;

	typedef struct packed {
		logic          kind;
		logic [NW-1:0] hit_number;
		logic [PW-1:0] hit_prime;
		logic          overflow;
		logic          last;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_DIV, S_LDWR, S_EMIT, S_READ, S_CALC, S_WB, S_DRD, S_DOUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_TAKE, OP_CLEAR, OP_DIV, OP_LOAD_WR, OP_EMIT_LOAD, OP_STEP_INIT,
		OP_READ, OP_CALC, OP_WB, OP_DRAIN_READ, OP_DRAIN_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [StepW-1:0] step;
	} ctl_t;

	typedef struct packed {
		logic [1:0] func;
		logic       reject;
		logic       zero_res;
		logic       empty;
		logic       last_entry;
		logic       any_hit;
		logic       last_hit;
	} stat_t;

	// 10^digits(n), with n = 0 counted as one digit
	function automatic logic [SW-1:0] scale_of(input logic [NW-1:0] n);
		logic [SW-1:0] s;
		if (n < NW'(10))          s = SW'(10);
		else if (n < NW'(100))    s = SW'(100);
		else if (n < NW'(1000))   s = SW'(1000);
		else if (n < NW'(10000))  s = SW'(10000);
		else if (n < NW'(100000)) s = SW'(100000);
		else                      s = SW'(1000000);
		return s;
	endfunction

endpackage

>>> rtl/crtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crtd_ram #(
	parameter int W = 40,
	parameter int D = 1024
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                   wdata,
	input  logic                           re,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                   rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/crtd_ctrl.sv
// Sequencer of the trial divider: dispatch, load, per-entry sweep and hit drain.
module crtd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  crtd_pkg::stat_t       stat,
	output crtd_pkg::ctl_t        ctl,
	output logic                  busy
);

	crtd_pkg::state_t state_q, state_d;
	logic [crtd_pkg::StepW-1:0] mc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crtd_pkg::S_IDLE;
			mc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == crtd_pkg::S_DIV || state_q == crtd_pkg::S_CALC) begin
				mc_q <= mc_q + 1'b1;
			end else begin
				mc_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			crtd_pkg::S_IDLE: begin
				if (start) state_d = crtd_pkg::S_DISP;
			end
			crtd_pkg::S_DISP: begin
				case (stat.func)
					crtd_pkg::FUNC_LOAD: begin
						state_d = stat.reject ? crtd_pkg::S_EMIT : crtd_pkg::S_DIV;
					end
					crtd_pkg::FUNC_STEP: begin
						state_d = stat.empty ? crtd_pkg::S_IDLE : crtd_pkg::S_READ;
					end
					default: state_d = crtd_pkg::S_IDLE;
				endcase
			end
			crtd_pkg::S_DIV: begin
				if (mc_q == crtd_pkg::StepW'(crtd_pkg::DivSteps - 1)) state_d = crtd_pkg::S_LDWR;
			end
			crtd_pkg::S_LDWR: begin
				state_d = stat.zero_res ? crtd_pkg::S_EMIT : crtd_pkg::S_IDLE;
			end
			crtd_pkg::S_EMIT: state_d = crtd_pkg::S_IDLE;
			crtd_pkg::S_READ: state_d = crtd_pkg::S_CALC;
			crtd_pkg::S_CALC: begin
				if (mc_q == crtd_pkg::StepW'(crtd_pkg::CalcSteps - 1)) state_d = crtd_pkg::S_WB;
			end
			crtd_pkg::S_WB: begin
				if (!stat.last_entry) state_d = crtd_pkg::S_READ;
				else if (stat.any_hit) state_d = crtd_pkg::S_DRD;
				else state_d = crtd_pkg::S_IDLE;
			end
			crtd_pkg::S_DRD: state_d = crtd_pkg::S_DOUT;
			crtd_pkg::S_DOUT: begin
				state_d = stat.last_hit ? crtd_pkg::S_IDLE : crtd_pkg::S_DRD;
			end
			default: state_d = crtd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.op   = crtd_pkg::OP_NOP;
		ctl.step = mc_q;
		case (state_q)
			crtd_pkg::S_IDLE: ctl.op = start ? crtd_pkg::OP_TAKE : crtd_pkg::OP_NOP;
			crtd_pkg::S_DISP: begin
				case (stat.func)
					crtd_pkg::FUNC_CLEAR: ctl.op = crtd_pkg::OP_CLEAR;
					crtd_pkg::FUNC_STEP:  ctl.op = crtd_pkg::OP_STEP_INIT;
					default:              ctl.op = crtd_pkg::OP_NOP;
				endcase
			end
			crtd_pkg::S_DIV:  ctl.op = crtd_pkg::OP_DIV;
			crtd_pkg::S_LDWR: ctl.op = crtd_pkg::OP_LOAD_WR;
			crtd_pkg::S_EMIT: ctl.op = crtd_pkg::OP_EMIT_LOAD;
			crtd_pkg::S_READ: ctl.op = crtd_pkg::OP_READ;
			crtd_pkg::S_CALC: ctl.op = crtd_pkg::OP_CALC;
			crtd_pkg::S_WB:   ctl.op = crtd_pkg::OP_WB;
			crtd_pkg::S_DRD:  ctl.op = crtd_pkg::OP_DRAIN_READ;
			crtd_pkg::S_DOUT: ctl.op = crtd_pkg::OP_DRAIN_EMIT;
			default:          ctl.op = crtd_pkg::OP_NOP;
		endcase
	end

	assign busy = (state_q != crtd_pkg::S_IDLE);

endmodule

>>> rtl/crtd_datapath.sv
// Datapath: entry tables, shared 32x32 multiplier, Barrett reduction, divider, hit buffer.
module crtd_datapath #(
	parameter int ENTRIES    = 1024,
	parameter int PRIME_BITS = 40,
	parameter int MAX_HITS   = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crtd_pkg::cmd_t      cmd,
	input  crtd_pkg::ctl_t      ctl,
	output crtd_pkg::stat_t     stat,
	output logic                strobe,
	output crtd_pkg::result_t   result
);

	localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int HAW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int HCW = $clog2(MAX_HITS + 1);
	localparam int PW  = crtd_pkg::PW;
	localparam int MW  = crtd_pkg::MW;

	crtd_pkg::cmd_t cmd_q;
	logic           rej_q;
	logic [CW-1:0]  cnt_q;
	logic [AW-1:0]  idx_q;
	logic [HCW-1:0] hits_q;
	logic [HAW-1:0] didx_q;
	logic           ovf_q;
	logic [PW-1:0]  rem_q;
	logic [MW-1:0]  bq_q;
	logic [127:0]   acc_q;
	logic [60:0]    x_q;
	logic [47:0]    q_q;
	logic [47:0]    r_q;
	crtd_pkg::result_t out_q;
	logic           stb_q;

	logic [PW-1:0] prime_rd, res_rd, hit_rd;
	logic [MW-1:0] barr_rd;
	logic [crtd_pkg::SW-1:0] scale;
	logic [31:0]   mul_a, mul_b;
	logic [63:0]   prod;
	logic [PW:0]   div_t;
	logic          full, p_small, p_wide, r_big, r_zero;
	logic          res_we;
	logic [AW-1:0] res_waddr;
	logic [PW-1:0] res_wdata;
	logic          hit_we;

	assign scale  = crtd_pkg::scale_of(cmd_q.number);
	assign r_zero = (r_q == '0);

	// load acceptance check on the incoming transaction
	assign full    = (cnt_q == CW'(ENTRIES));
	assign p_small = (cmd.prime < PW'(2));
	assign p_wide  = (PRIME_BITS < PW) && ((cmd.prime >> PRIME_BITS) != '0);
	assign r_big   = (cmd.start_residue >= cmd.prime);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.step)
			6'd0: begin mul_a = 32'(res_rd[19:0]);  mul_b = 32'(scale); end
			6'd1: begin mul_a = 32'(res_rd[39:20]); mul_b = 32'(scale); end
			6'd2: begin mul_a = x_q[31:0];           mul_b = barr_rd[31:0]; end
			6'd3: begin mul_a = x_q[31:0];           mul_b = barr_rd[63:32]; end
			6'd4: begin mul_a = 32'(x_q[60:32]);     mul_b = barr_rd[31:0]; end
			6'd5: begin mul_a = 32'(x_q[60:32]);     mul_b = barr_rd[63:32]; end
			6'd6: begin mul_a = 32'(q_q[23:0]);      mul_b = 32'(prime_rd[23:0]); end
			6'd7: begin mul_a = 32'(q_q[23:0]);      mul_b = 32'(prime_rd[39:24]); end
			6'd8: begin mul_a = 32'(q_q[47:24]);     mul_b = 32'(prime_rd[23:0]); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign div_t = {rem_q, 1'b1};

	always_ff @(posedge clk) begin
		case (ctl.op)
			crtd_pkg::OP_TAKE: begin
				cmd_q <= cmd;
				rej_q <= full || p_small || p_wide || r_big;
				rem_q <= '0;
			end
			crtd_pkg::OP_DIV: begin
				if (div_t >= {1'b0, cmd_q.prime}) begin
					rem_q <= PW'(div_t - {1'b0, cmd_q.prime});
					bq_q  <= {bq_q[MW-2:0], 1'b1};
				end else begin
					rem_q <= div_t[PW-1:0];
					bq_q  <= {bq_q[MW-2:0], 1'b0};
				end
			end
			crtd_pkg::OP_CALC: begin
				case (ctl.step)
					6'd0: acc_q <= 128'(prod) + 128'(cmd_q.number);
					6'd1: begin
						x_q   <= 61'(acc_q + (128'(prod) << 20));
						acc_q <= '0;
					end
					6'd2: acc_q <= acc_q + 128'(prod);
					6'd3, 6'd4: acc_q <= acc_q + (128'(prod) << 32);
					6'd5: begin
						q_q   <= 48'((acc_q + (128'(prod) << 64)) >> 64);
						acc_q <= '0;
					end
					6'd6: acc_q <= 128'(prod);
					6'd7, 6'd8: acc_q <= acc_q + (128'(prod) << 24);
					// true remainder is below 3p, so the low bits are exact
					6'd9: r_q <= x_q[47:0] - acc_q[47:0];
					6'd10, 6'd11: begin
						if (r_q >= 48'(prime_rd)) r_q <= r_q - 48'(prime_rd);
					end
					default: r_q <= r_q;
				endcase
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			hits_q <= '0;
			didx_q <= '0;
			ovf_q  <= 1'b0;
			stb_q  <= 1'b0;
		end else begin
			stb_q <= 1'b0;
			case (ctl.op)
				crtd_pkg::OP_CLEAR:   cnt_q <= '0;
				crtd_pkg::OP_LOAD_WR: cnt_q <= cnt_q + 1'b1;
				crtd_pkg::OP_STEP_INIT: begin
					idx_q  <= '0;
					hits_q <= '0;
					didx_q <= '0;
					ovf_q  <= 1'b0;
				end
				crtd_pkg::OP_WB: begin
					idx_q <= idx_q + 1'b1;
					if (r_zero) begin
						if (hits_q != HCW'(MAX_HITS)) hits_q <= hits_q + 1'b1;
						else ovf_q <= 1'b1;
					end
				end
				crtd_pkg::OP_EMIT_LOAD: stb_q <= 1'b1;
				crtd_pkg::OP_DRAIN_EMIT: begin
					stb_q  <= 1'b1;
					didx_q <= didx_q + 1'b1;
				end
				default: stb_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			crtd_pkg::OP_EMIT_LOAD: begin
				out_q.kind       <= rej_q ? crtd_pkg::KIND_REJECT : crtd_pkg::KIND_HIT;
				out_q.hit_number <= cmd_q.number;
				out_q.hit_prime  <= cmd_q.prime;
				out_q.overflow   <= 1'b0;
				out_q.last       <= 1'b1;
			end
			crtd_pkg::OP_DRAIN_EMIT: begin
				out_q.kind       <= crtd_pkg::KIND_HIT;
				out_q.hit_number <= cmd_q.number;
				out_q.hit_prime  <= hit_rd;
				out_q.overflow   <= ovf_q;
				out_q.last       <= stat.last_hit;
			end
			default: out_q <= out_q;
		endcase
	end

	assign res_we    = (ctl.op == crtd_pkg::OP_LOAD_WR) || (ctl.op == crtd_pkg::OP_WB);
	assign res_waddr = (ctl.op == crtd_pkg::OP_WB) ? idx_q : cnt_q[AW-1:0];
	assign res_wdata = (ctl.op == crtd_pkg::OP_WB) ? r_q[PW-1:0] : cmd_q.start_residue;
	assign hit_we    = (ctl.op == crtd_pkg::OP_WB) && r_zero && (hits_q != HCW'(MAX_HITS));

	crtd_ram #(.W(PW), .D(ENTRIES)) u_prime_ram (
		.clk(clk), .we(ctl.op == crtd_pkg::OP_LOAD_WR), .waddr(cnt_q[AW-1:0]),
		.wdata(cmd_q.prime), .re(ctl.op == crtd_pkg::OP_READ), .raddr(idx_q),
		.rdata(prime_rd)
	);

	crtd_ram #(.W(PW), .D(ENTRIES)) u_res_ram (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.re(ctl.op == crtd_pkg::OP_READ), .raddr(idx_q), .rdata(res_rd)
	);

	crtd_ram #(.W(MW), .D(ENTRIES)) u_barr_ram (
		.clk(clk), .we(ctl.op == crtd_pkg::OP_LOAD_WR), .waddr(cnt_q[AW-1:0]),
		.wdata(bq_q), .re(ctl.op == crtd_pkg::OP_READ), .raddr(idx_q), .rdata(barr_rd)
	);

	crtd_ram #(.W(PW), .D(MAX_HITS)) u_hit_ram (
		.clk(clk), .we(hit_we), .waddr(hits_q[HAW-1:0]), .wdata(prime_rd),
		.re(ctl.op == crtd_pkg::OP_DRAIN_READ), .raddr(didx_q), .rdata(hit_rd)
	);

	always_comb begin
		stat.func       = cmd_q.func;
		stat.reject     = rej_q;
		stat.zero_res   = (cmd_q.start_residue == '0);
		stat.empty      = (cnt_q == '0);
		stat.last_entry = ((CW'(idx_q) + 1'b1) == cnt_q);
		stat.any_hit    = (hits_q != '0) || r_zero;
		stat.last_hit   = ((HCW'(didx_q) + 1'b1) == hits_q);
	end

	assign strobe = stb_q;
	assign result = out_q;

endmodule

>>> rtl/concat_residue_trial_divider.sv
// Top level of the concatenation residue trial divider.
// An accepted load holds busy through dispatch, a restoring divide for the Barrett multiplier
// and then the table write; a zero residue adds an emit state for its hit. A rejected load
// goes from dispatch straight to the emit state.
// A step sweeps the table entry by entry (one read, twelve calculation steps that use the
// shared 32x32 multiplier and then correct, one write-back), then drains each hit by a read
// and an emit. One transaction runs at a time; busy covers it up to its final emit state.
// Reset clears the entry count and the sequencer; table contents are not cleared.
module concat_residue_trial_divider #(
	parameter int ENTRIES    = 1024,
	parameter int PRIME_BITS = 40,
	parameter int MAX_HITS   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  crtd_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              strobe,
	output crtd_pkg::result_t result
);

	// command and status between sequencer and datapath
	crtd_pkg::ctl_t  ctl;
	crtd_pkg::stat_t stat;

	// sequencer: dispatch by func, hold busy for the transaction
	crtd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .ctl(ctl), .busy(busy)
	);

	// datapath: tables, reduction and registered result port
	crtd_datapath #(
		.ENTRIES(ENTRIES), .PRIME_BITS(PRIME_BITS), .MAX_HITS(MAX_HITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ctl(ctl), .stat(stat),
		.strobe(strobe), .result(result)
	);

endmodule

>>> rtl/crtd_checker.sv
// Port-level checker for the trial divider, bound to the top level.
module crtd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input crtd_pkg::result_t result
);

	// an accepted transaction holds busy on the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	// a rejected load is always the final result of its transaction
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.kind == crtd_pkg::KIND_REJECT) |-> result.last)
		else $error("reject result without last");

	// overflow only comes with step hits
	a_ovf_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.overflow) |-> (result.kind == crtd_pkg::KIND_HIT))
		else $error("overflow on a reject result");

	// overflow is constant across the results of one step
	a_ovf_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) ##2 strobe |-> (result.overflow == $past(result.overflow, 2)))
		else $error("overflow changed within a step");

endmodule

bind concat_residue_trial_divider crtd_checker u_crtd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .result(result)
);

>>> test/tb_top.sv
// Testbench for the concatenation residue trial divider: random and directed commands, scoreboard check.
`timescale 1ns / 1ps

module tb_top;

	localparam int TABLE_DEPTH = 1024;
	localparam int HIT_CAP = 64;
	// a step over a full table accepts nothing and emits nothing until its sweep ends
	localparam int STALL_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic start;
	crtd_pkg::cmd_t cmd;
	logic busy;
	logic strobe;
	crtd_pkg::result_t result;

	concat_residue_trial_divider u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow copy of the prime table
	logic [crtd_pkg::PW-1:0] shadow_prime [TABLE_DEPTH];
	logic [crtd_pkg::PW-1:0] shadow_res [TABLE_DEPTH];
	int unsigned shadow_count = 0;

	crtd_pkg::cmd_t pending_cmds [$];
	crtd_pkg::result_t expected_hits [$];
	int error_count = 0;
	bit quiet_phase = 1'b0;
	bit took;
	int idle_left;
	int stall_cycles;

	// compute the results of one accepted command and advance the shadow table
	task automatic predict_command(input crtd_pkg::cmd_t c);
		longint unsigned scale;
		longint unsigned r;
		crtd_pkg::result_t e;
		crtd_pkg::result_t found [$];
		bit ovf;
		ovf = 1'b0;
		case (c.func)
			crtd_pkg::FUNC_CLEAR: shadow_count = 0;
			crtd_pkg::FUNC_LOAD: begin
				e = '0;
				e.hit_number = c.number;
				e.hit_prime = c.prime;
				e.last = 1'b1;
				if (shadow_count >= TABLE_DEPTH || c.prime < 2 || c.start_residue >= c.prime) begin
					e.kind = crtd_pkg::KIND_REJECT;
					expected_hits.push_back(e);
				end else begin
					shadow_prime[shadow_count] = c.prime;
					shadow_res[shadow_count] = c.start_residue;
					shadow_count++;
					if (c.start_residue == 0) begin
						e.kind = crtd_pkg::KIND_HIT;
						expected_hits.push_back(e);
					end
				end
			end
			crtd_pkg::FUNC_STEP: begin
				scale = 10;
				while (scale <= c.number)
					scale *= 10;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_prime[i] == 2)
						r = c.number & 1;
					else
						r = (shadow_res[i] * scale + c.number) % shadow_prime[i];
					shadow_res[i] = r[crtd_pkg::PW-1:0];
					if (r == 0) begin
						if (found.size() < HIT_CAP) begin
							e = '0;
							e.kind = crtd_pkg::KIND_HIT;
							e.hit_number = c.number;
							e.hit_prime = shadow_prime[i];
							found.push_back(e);
						end else
							ovf = 1'b1;
					end
				end
				foreach (found[k]) begin
					found[k].overflow = ovf;
					found[k].last = (k == found.size() - 1);
					expected_hits.push_back(found[k]);
				end
			end
			default: ;
		endcase
	endtask

	function automatic crtd_pkg::cmd_t make_cmd(input logic [1:0] f, input longint unsigned p,
		input longint unsigned r, input int unsigned n);
		crtd_pkg::cmd_t c;
		c.func = f;
		c.prime = p[crtd_pkg::PW-1:0];
		c.start_residue = r[crtd_pkg::PW-1:0];
		c.number = n[crtd_pkg::NW-1:0];
		return c;
	endfunction

	// pick mostly small primes so steps produce frequent hits; one pick in ten is a random odd value
	function automatic longint unsigned pick_prime();
		int unsigned pool [12] = '{2, 3, 5, 7, 11, 13, 37, 101, 3607, 3803, 65537, 999983};
		if ($urandom_range(0, 9) == 0)
			return {$urandom_range(0, 255), $urandom} | 1;
		return pool[$urandom_range(0, 11)];
	endfunction

	// driver: hold a transaction until accepted, then idle at random or present the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			idle_left <= 0;
		end else if (start && !took) begin
			// hold until the rising edge accepts it
		end else if (idle_left > 0) begin
			start <= 1'b0;
			idle_left <= idle_left - 1;
		end else if (took && !quiet_phase && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			idle_left <= $urandom_range(1, 8) - 1;
		end else if (pending_cmds.size() > 0) begin
			cmd <= pending_cmds.pop_front();
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: accept commands and results at the rising edge
	always @(posedge clk) begin
		took <= arst_n && start && !busy;
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((start && !busy) || strobe)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (start && !busy)
				predict_command(cmd);
			if (strobe) begin
				if (expected_hits.size() == 0) begin
					$error("unexpected result: prime %0d number %0d", result.hit_prime,
						result.hit_number);
					error_count++;
				end else begin
					crtd_pkg::result_t e;
					e = expected_hits.pop_front();
					if (e.kind != result.kind) begin
						$error("kind: expected %0d actual %0d", e.kind, result.kind);
						error_count++;
					end
					if (e.hit_number != result.hit_number) begin
						$error("hit_number: expected %0d actual %0d", e.hit_number,
							result.hit_number);
						error_count++;
					end
					if (e.hit_prime != result.hit_prime) begin
						$error("hit_prime: expected %0d actual %0d", e.hit_prime,
							result.hit_prime);
						error_count++;
					end
					if (e.overflow != result.overflow) begin
						$error("overflow: expected %0d actual %0d", e.overflow,
							result.overflow);
						error_count++;
					end
					if (e.last != result.last) begin
						$error("last: expected %0d actual %0d", e.last, result.last);
						error_count++;
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("concat_residue_trial_divider verification failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned seq_n;
		longint unsigned p;
		arst_n = 1'b0;

		// directed: rejects, zero residue load, prime two, digit boundaries, unused func
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 5));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 0, 0, 0));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 1, 0, 1));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 7, 7, 2));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 40'hFF_FFFF_FFFF,
			40'hFF_FFFF_FFFF, 131071));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 2, 0, 3));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 3, 1, 4));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 40'hFF_FFFF_FFFB,
			40'hFF_FFFF_FFFA, 0));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 11, 0, 99999));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 0));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 9));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 10));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 99999));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 100000));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 131071));
		pending_cmds.push_back(make_cmd(2'd3, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 131071));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 12));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_CLEAR, 0, 0, 0));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 2));
		// saturation: 70 copies of three with zero residue, then a step that hits them all
		for (int i = 0; i < 70; i++)
			pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, 3, 0, i));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 3));
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_CLEAR, 0, 0, 0));

		// random: sessions of loads followed by consecutive steps
		for (int s = 0; s < 11; s++) begin
			int loads;
			loads = $urandom_range(1, 12);
			for (int i = 0; i < loads; i++) begin
				p = pick_prime();
				if ($urandom_range(0, 9) == 0)
					pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, {$urandom, $urandom},
						{$urandom, $urandom}, $urandom_range(0, 131071)));
				else
					pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, p,
						($urandom_range(0, 3) == 0) ? 0 : {$urandom, $urandom} % p,
						$urandom_range(0, 131071)));
			end
			seq_n = $urandom_range(0, 131050);
			for (int i = 0; i < 14; i++) begin
				if ($urandom_range(0, 15) == 0)
					pending_cmds.push_back(make_cmd(2'($urandom_range(0, 3)),
						{$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 131071)));
				else
					pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, {$urandom, $urandom},
						{$urandom, $urandom}, ($urandom_range(0, 4) == 0) ?
						$urandom_range(0, 131071) : seq_n + i));
			end
			if ($urandom_range(0, 1))
				pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_CLEAR, {$urandom, $urandom},
					{$urandom, $urandom}, $urandom_range(0, 131071)));
		end
		pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_CLEAR, 0, 0, 0));
		// last part without gaps
		for (int i = 0; i < 20; i++)
			pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_LOAD, pick_prime(), 0, i));
		for (int i = 0; i < 10; i++)
			pending_cmds.push_back(make_cmd(crtd_pkg::FUNC_STEP, 0, 0, 500 + i));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_cmds.size() < 40);
		quiet_phase = 1'b1;
		wait (pending_cmds.size() == 0);
		wait (!start);
		@(posedge clk);
		wait (!busy);
		wait (expected_hits.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_hits.size() == 0)
			$display("concat_residue_trial_divider verification clean");
		else
			$display("concat_residue_trial_divider verification failed");
		$finish;
	end

endmodule
